// ===== hdl/stable_four_level_priority_queue_top_assert.svh =====
// Assertion macros used by the priority queue datapath.
// Each macro takes a label, clock, active-low reset, the checked terms and a message.
`ifndef STABLE_FOUR_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_FOUR_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define SFPQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SFPQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sfpq_pkg.sv =====
// Package for the stable four-level priority queue.
// Holds the entry type, status codes, controller command/status structs and defaults.
package sfpq_pkg;

    localparam int P_CAPACITY = 16;

    localparam logic [2:0] PRIO_MOST  = 3'd1;
    localparam logic [2:0] PRIO_LEAST = 3'd4;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_POPPED   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_BAD_PRIO = 3'd4
    } t_status;

    typedef struct packed {
        logic [15:0] patient;
        logic [15:0] doctor;
        logic [2:0]  prio;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    pop;
        logic    capture;
        t_status status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic prio_ok;
    } t_dp_stat;

endpackage

// ===== hdl/stable_four_level_priority_queue_top.sv =====
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_req_type .. i_date_day
// result    out        o_valid / i_stall  o_status .. o_occupancy
//
// Each request goes through accept, an update of the sorted cell row with result capture,
// then the result word is held until taken. The next request is accepted in the
// cycle after the result is taken. Synchronous active-low reset empties the queue.
// The request side stalls from acceptance until the result word leaves.
// Top level of the priority queue; depends on sfpq_pkg, sfpq_ctrl and sfpq_dp.
module stable_four_level_priority_queue_top
    import sfpq_pkg::*;
#(
    parameter int CAPACITY = P_CAPACITY
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_patient_id,
    input  logic [15:0] i_doctor_id,
    input  logic [2:0]  i_priority_req,
    input  logic [13:0] i_date_year,
    input  logic [3:0]  i_date_month,
    input  logic [4:0]  i_date_day,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_patient,
    output logic [15:0] o_out_doctor,
    output logic [2:0]  o_out_priority,
    output logic [13:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [4:0]  o_occupancy
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sfpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sfpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_req_type     (i_req_type),
        .i_patient_id   (i_patient_id),
        .i_doctor_id    (i_doctor_id),
        .i_priority_req (i_priority_req),
        .i_date_year    (i_date_year),
        .i_date_month   (i_date_month),
        .i_date_day     (i_date_day),
        .o_status       (o_status),
        .o_out_patient  (o_out_patient),
        .o_out_doctor   (o_out_doctor),
        .o_out_priority (o_out_priority),
        .o_out_year     (o_out_year),
        .o_out_month    (o_out_month),
        .o_out_day      (o_out_day),
        .o_occupancy    (o_occupancy)
    );

endmodule

// ===== hdl/sfpq_ctrl.sv =====
// Controller for the priority queue: accept, execute, deliver sequence.
// Depends on sfpq_pkg for the command and status structs.
module sfpq_ctrl
    import sfpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;
    logic   r_valid, n_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_stall = r_stall;
        n_valid = r_valid;
        o_cmd.status = ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                    n_stall    = 1'b1;
                end
            end
            S_RUN: begin
                o_cmd.capture = 1'b1;
                if (i_stat.is_pop) begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.status = ST_POPPED;
                        o_cmd.pop    = 1'b1;
                    end
                end else if (!i_stat.prio_ok) begin
                    o_cmd.status = ST_BAD_PRIO;
                end else if (i_stat.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.status = ST_INSERTED;
                    o_cmd.insert = 1'b1;
                end
                n_state = S_DONE;
                n_valid = 1'b1;
            end
            S_DONE: begin
                // release the word once the sink takes it
                if (!i_stall) begin
                    n_state = S_IDLE;
                    n_valid = 1'b0;
                    n_stall = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_valid = 1'b0;
                n_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
            r_valid <= n_valid;
        end
    end

    assign o_stall = r_stall;
    assign o_valid = r_valid;

endmodule

// ===== hdl/sfpq_dp.sv =====
// Datapath for the priority queue: request latch, sorted row of cells, count, result register.
// Depends on sfpq_pkg and the assertion macros header.
`include "stable_four_level_priority_queue_top_assert.svh"
module sfpq_dp
    import sfpq_pkg::*;
#(
    parameter int CAPACITY = P_CAPACITY
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_req_type,
    input  logic [15:0] i_patient_id,
    input  logic [15:0] i_doctor_id,
    input  logic [2:0]  i_priority_req,
    input  logic [13:0] i_date_year,
    input  logic [3:0]  i_date_month,
    input  logic [4:0]  i_date_day,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_patient,
    output logic [15:0] o_out_doctor,
    output logic [2:0]  o_out_priority,
    output logic [13:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [4:0]  o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic             r_req_type;
    t_entry           r_new;
    logic [CNT_W-1:0] r_count, n_count;
    t_entry           r_cell [CAPACITY];
    t_entry           n_cell [CAPACITY];
    logic [CAPACITY-1:0] w_keep;
    t_status          r_status;
    t_entry           r_out;
    logic [4:0]       r_occ;

    // latch the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_new      <= '{patient: i_patient_id, doctor: i_doctor_id,
                            prio: i_priority_req, year: i_date_year,
                            month: i_date_month, day: i_date_day};
        end
    end

    always_comb begin
        o_stat.is_pop  = r_req_type;
        o_stat.empty   = (r_count == '0);
        o_stat.full    = (r_count >= CNT_FULL);
        o_stat.prio_ok = (r_new.prio >= PRIO_MOST) && (r_new.prio <= PRIO_LEAST);
    end

    // each cell looks only at itself, its two neighbors, the new entry and the count
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);

        assign w_keep[gi] = (IDX < r_count) && (r_cell[gi].prio <= r_new.prio);

        always_comb begin
            n_cell[gi] = r_cell[gi];
            if (i_cmd.insert) begin
                if (w_keep[gi]) begin
                    n_cell[gi] = r_cell[gi];
                end else if (gi == 0) begin
                    n_cell[gi] = r_new;
                end else if (w_keep[(gi == 0) ? 0 : gi - 1]) begin
                    n_cell[gi] = r_new;
                end else begin
                    n_cell[gi] = r_cell[(gi == 0) ? 0 : gi - 1];
                end
            end else if (i_cmd.pop) begin
                if (gi < CAPACITY - 1) begin
                    n_cell[gi] = r_cell[(gi < CAPACITY - 1) ? gi + 1 : gi];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert || i_cmd.pop) begin
                r_cell[gi] <= n_cell[gi];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CNT_ONE;
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result word: head on a pop, zeros otherwise
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_status <= i_cmd.status;
            r_out    <= i_cmd.pop ? r_cell[0] : '0;
            r_occ    <= 5'(n_count);
        end
    end

    assign o_status       = r_status;
    assign o_out_patient  = r_out.patient;
    assign o_out_doctor   = r_out.doctor;
    assign o_out_priority = r_out.prio;
    assign o_out_year     = r_out.year;
    assign o_out_month    = r_out.month;
    assign o_out_day      = r_out.day;
    assign o_occupancy    = r_occ;

    `SFPQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "count above capacity")
    `SFPQ_ASSERT_ALWAYS(a_insert_legal, i_clk, i_rst_n,
        !i_cmd.insert || (!o_stat.full && o_stat.prio_ok && !i_cmd.pop), "illegal insert")
    `SFPQ_ASSERT_NEXT(a_pop_dec, i_clk, i_rst_n, i_cmd.pop,
        r_count == $past(r_count) - CNT_ONE, "pop did not decrement count")

endmodule

// ===== dv/stable_four_level_priority_queue_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for stable_four_level_priority_queue_top: sends insert and pop requests and
// checks every result word against a sorted-queue scoreboard held in a small class.
// Depends on sfpq_pkg and the priority queue RTL.
module stable_four_level_priority_queue_top_tb;
    import sfpq_pkg::*;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam int PHASE_ITEMS = 417;
    localparam int HOLD_CYCLES = 90;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TIMEOUT_NS  = 2_400_000;

    typedef struct {
        logic   req_type;
        t_entry ent;
    } t_request;

    typedef struct {
        t_status    status;
        t_entry     ent;
        logic [4:0] occupancy;
    } t_result;

    class t_triage_scoreboard;
        t_entry      waiting_entries[$];
        t_result     due_results[$];
        int unsigned mismatch_count;
        int unsigned status_tally[5];
        int unsigned peak_count;

        // Work out the result word for one accepted request and advance the queue.
        function void note_request(t_request r);
            t_result     want;
            int unsigned pos;
            want.status = ST_INSERTED;
            want.ent    = '0;
            if (r.req_type == REQ_INSERT) begin
                if (r.ent.prio < PRIO_MOST || r.ent.prio > PRIO_LEAST) begin
                    want.status = ST_BAD_PRIO;
                end else if (waiting_entries.size() >= P_CAPACITY) begin
                    want.status = ST_FULL;
                end else begin
                    // go behind every entry of equal or more urgent priority
                    pos = 0;
                    while (pos < waiting_entries.size() &&
                           waiting_entries[pos].prio <= r.ent.prio)
                        pos++;
                    waiting_entries.insert(pos, r.ent);
                end
            end else if (waiting_entries.size() == 0) begin
                want.status = ST_EMPTY;
            end else begin
                want.status = ST_POPPED;
                want.ent    = waiting_entries.pop_front();
            end
            want.occupancy = 5'(waiting_entries.size());
            if (waiting_entries.size() > peak_count)
                peak_count = waiting_entries.size();
            status_tally[want.status]++;
            due_results.push_back(want);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual status %0d",
                         $time, got.status);
                mismatch_count++;
                return;
            end
            want = due_results.pop_front();
            check_field("status",    want.status,     got.status);
            check_field("patient",   want.ent.patient, got.ent.patient);
            check_field("doctor",    want.ent.doctor,  got.ent.doctor);
            check_field("priority",  want.ent.prio,    got.ent.prio);
            check_field("year",      want.ent.year,    got.ent.year);
            check_field("month",     want.ent.month,   got.ent.month);
            check_field("day",       want.ent.day,     got.ent.day);
            check_field("occupancy", want.occupancy,   got.occupancy);
        endfunction

        function void report_leftovers();
            foreach (due_results[k]) begin
                $display("%0t ns: result never arrived, expected status %0d occupancy %0d, %s",
                         $time, due_results[k].status, due_results[k].occupancy,
                         "actual none");
                mismatch_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [15:0] i_patient_id;
    logic [15:0] i_doctor_id;
    logic [2:0]  i_priority_req;
    logic [13:0] i_date_year;
    logic [3:0]  i_date_month;
    logic [4:0]  i_date_day;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [15:0] o_out_patient;
    logic [15:0] o_out_doctor;
    logic [2:0]  o_out_priority;
    logic [13:0] o_out_year;
    logic [3:0]  o_out_month;
    logic [4:0]  o_out_day;
    logic [4:0]  o_occupancy;

    t_triage_scoreboard sb;
    int unsigned      send_idle_pct = 31;
    int unsigned      recv_idle_pct = 52;
    logic             hold_off_req  = 1'b0;
    int unsigned      hold_left     = 0;
    int unsigned      hold_count    = 0;
    int unsigned      requests_sent = 0;

    stable_four_level_priority_queue_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_patient_id   (i_patient_id),
        .i_doctor_id    (i_doctor_id),
        .i_priority_req (i_priority_req),
        .i_date_year    (i_date_year),
        .i_date_month   (i_date_month),
        .i_date_day     (i_date_day),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_patient  (o_out_patient),
        .o_out_doctor   (o_out_doctor),
        .o_out_priority (o_out_priority),
        .o_out_year     (o_out_year),
        .o_out_month    (o_out_month),
        .o_out_day      (o_out_day),
        .o_occupancy    (o_occupancy)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request so the request side backs up.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_count++;
            hold_left = HOLD_CYCLES - 1;
            i_stall = 1'b1;
        end else begin
            i_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status      = t_status'(o_status);
            got.ent.patient = o_out_patient;
            got.ent.doctor  = o_out_doctor;
            got.ent.prio    = o_out_priority;
            got.ent.year    = o_out_year;
            got.ent.month   = o_out_month;
            got.ent.day     = o_out_day;
            got.occupancy   = o_occupancy;
            sb.check_result(got);
        end
    end

    function automatic t_request make_req(logic req_type, logic [2:0] prio,
                                          logic [15:0] patient, logic [15:0] doctor,
                                          logic [13:0] year, logic [3:0] month,
                                          logic [4:0] day);
        t_request r;
        r.req_type    = req_type;
        r.ent.patient = patient;
        r.ent.doctor  = doctor;
        r.ent.prio    = prio;
        r.ent.year    = year;
        r.ent.month   = month;
        r.ent.day     = day;
        return r;
    endfunction

    function automatic t_request random_request(int unsigned insert_pct, int unsigned prio_top);
        t_request    r;
        int unsigned pick;
        r.req_type    = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_POP;
        r.ent.patient = 16'($urandom);
        r.ent.doctor  = 16'($urandom);
        if ($urandom_range(9) == 0) begin
            pick       = $urandom_range(3);
            r.ent.prio = (pick == 0) ? 3'd0 : 3'(PRIO_LEAST + pick);
        end else begin
            r.ent.prio = 3'($urandom_range(PRIO_MOST, prio_top));
        end
        // mostly calendar-like dates, now and then any bit pattern
        if ($urandom_range(15) == 0) begin
            r.ent.year  = 14'($urandom);
            r.ent.month = 4'($urandom);
            r.ent.day   = 5'($urandom);
        end else begin
            r.ent.year  = 14'($urandom_range(9999));
            r.ent.month = 4'($urandom_range(1, 12));
            r.ent.day   = 5'($urandom_range(1, 31));
        end
        return r;
    endfunction

    task automatic send_request(input t_request r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_req_type     = r.req_type;
        i_patient_id   = r.ent.patient;
        i_doctor_id    = r.ent.doctor;
        i_priority_req = r.ent.prio;
        i_date_year    = r.ent.year;
        i_date_month   = r.ent.month;
        i_date_day     = r.ent.day;
        // hold the word until the queue takes it
        do @(posedge i_clk); while (o_stall);
        sb.note_request(r);
        requests_sent++;
    endtask

    // Each segment is picked at random: filling toward full, draining, or a balanced mix.
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned seg_len;
        int unsigned insert_pct;
        int unsigned prio_top;
        int unsigned k;
        sent = 0;
        while (sent < n_items) begin
            seg_len = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       insert_pct = 85;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            prio_top = $urandom_range(PRIO_MOST, PRIO_LEAST);
            for (k = 0; k < seg_len && sent < n_items; k++) begin
                if (sent == n_items / 3)
                    hold_off_req = 1'b1;
                send_request(random_request(insert_pct, prio_top));
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned drain_cycles;
        sb             = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_req_type     = REQ_INSERT;
        i_patient_id   = '0;
        i_doctor_id    = '0;
        i_priority_req = '0;
        i_date_year    = '0;
        i_date_month   = '0;
        i_date_day     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(make_req(REQ_POP, 3'd0, '1, '1, '1, '1, '1));
        // out-of-range priorities, with every payload bit set
        send_request(make_req(REQ_INSERT, 3'd0, '1, '1, '1, '1, '1));
        send_request(make_req(REQ_INSERT, 3'd5, '1, '1, '1, '1, '1));
        send_request(make_req(REQ_INSERT, 3'd6, '1, '1, '1, '1, '1));
        send_request(make_req(REQ_INSERT, 3'd7, '1, '1, '1, '1, '1));
        // arrive least urgent first so each insert lands ahead of the last
        send_request(make_req(REQ_INSERT, PRIO_LEAST, 16'hffff, 16'h0000, 14'd9999, 4'd12, 5'd31));
        send_request(make_req(REQ_INSERT, 3'd3, 16'h0000, 16'hffff, 14'd0, 4'd1, 5'd1));
        send_request(make_req(REQ_INSERT, 3'd2, 16'ha5a5, 16'h5a5a, 14'h3fff, 4'd15, 5'd0));
        send_request(make_req(REQ_INSERT, PRIO_MOST, 16'h1234, 16'h4321, 14'd1, 4'd6, 5'd15));
        // equal priorities must leave in arrival order
        send_request(make_req(REQ_INSERT, 3'd2, 16'h5a5a, 16'ha5a5, 14'd5000, 4'd7, 5'd16));
        send_request(make_req(REQ_INSERT, PRIO_LEAST, 16'h8001, 16'h0180, 14'd8192, 4'd8, 5'd30));
        send_request(make_req(REQ_INSERT, PRIO_MOST, 16'h0000, 16'h0000, 14'd0, 4'd0, 5'd0));
        repeat (8) send_request(make_req(REQ_POP, 3'd0, '0, '0, '0, '0, '0));

        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 52;
        recv_idle_pct = 31;
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);
        @(negedge i_clk);
        i_valid = 1'b0;

        drain_cycles = 0;
        while (sb.due_results.size() > 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        sb.report_leftovers();

        $display("Run covered %0d requests: %0d stored, %0d popped, %0d pops on empty,",
                 requests_sent, sb.status_tally[ST_INSERTED], sb.status_tally[ST_POPPED],
                 sb.status_tally[ST_EMPTY]);
        $display("%0d full rejects, %0d bad priorities, peak depth %0d of %0d, %0d hold-offs.",
                 sb.status_tally[ST_FULL], sb.status_tally[ST_BAD_PRIO],
                 sb.peak_count, P_CAPACITY, hold_count);
        if (sb.mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout after %0d ns with %0d requests sent", TIMEOUT_NS, requests_sent);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== stable_four_level_priority_queue_top.f =====
+incdir+hdl
hdl/sfpq_pkg.sv
hdl/sfpq_ctrl.sv
hdl/sfpq_dp.sv
hdl/stable_four_level_priority_queue_top.sv
dv/stable_four_level_priority_queue_top_tb.sv
